// ===== design/ccse_pkg.sv =====
package ccse_pkg;

    localparam int MAX_POINTS  = 32;
    localparam int COORD_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int SEQ_W       = 15;
    localparam int OSEQ_W      = 16;
    localparam int LOOKBACK    = 2;
    // one stored entry: goal, seq, y, x
    localparam int ENT_W       = 1 + SEQ_W + 2 * COORD_WIDTH;
    // squared distance: two squares of COORD_WIDTH+1 bit magnitudes plus carry
    localparam int SQ_W        = 2 * (COORD_WIDTH + 1);
    localparam int DIST_W      = SQ_W + 1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_EMIT,
        ST_WRAP
    } state_t;

    typedef struct packed {
        logic [1:0]                    action;
        logic [SEQ_W-1:0]              point_seq;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic                          point_goal;
    } in_item_t;

    typedef struct packed {
        logic [OSEQ_W-1:0]             out_seq;
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          out_goal;
        logic                          last;
    } out_item_t;

endpackage

// ===== design/ccse_ram.sv =====
module ccse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/closest_continuous_segment_extract_unit.sv =====
// Closest continuous segment extractor.
// Command channel: an item transfers on a clock edge with start high and busy
// low. Clear and append give no result; busy stays low.
// Append beyond MAX_POINTS entries is dropped. A query raises busy, then
// scans the n stored points through one registered-read point memory
// (read, distance square and compare stages), then reads out the segment
// one point per cycle; each result appears in the cycle after its read.
// A query gives k results, k at most MAX_POINTS + 2. Empty store: no result.
// Results: valid pulses for one cycle with the result struct; last marks the
// final point. The receiver cannot stall; results are never held.
// Reset clears the point count and the control; memory contents are not
// cleared, and entries at or above the count are never read.
// The scan keeps the first index of least squared distance, the first
// sequence jump, the first jump after the running best, and the goal flag.
module closest_continuous_segment_extract_unit
    import ccse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  cmd,
    output logic      busy,
    output logic      valid,
    output out_item_t result
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // memory port
    logic             mem_we;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_wdata, mem_rdata;

    // scan registers
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;       // next address to read
    logic             s1_v_reg;                      // rdata valid this cycle
    logic [IDX_W-1:0] s1_i_reg;
    logic             s2_v_reg;
    logic [IDX_W-1:0] s2_i_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [SEQ_W-1:0] prev_seq_reg;
    logic             jump2_reg;                     // jump at s2 index
    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0]  c_reg;
    logic [CNT_W-1:0]  fj_reg, nj_reg;
    logic              goal_reg;
    logic [SEQ_W-1:0]  lastseq_reg;

    // emission registers
    logic [CNT_W-1:0]  end_reg, end_next;            // exclusive bound
    logic              wrap_reg, wrap_next;
    logic [CNT_W-1:0]  lead_reg, lead_next;
    logic [OSEQ_W-1:0] add_reg, add_next;
    logic              e_v_reg;                      // read issued last cycle
    logic              e_last_reg;
    logic              e_wrap_reg;
    logic              e_v_next, e_last_next, e_wrap_next;

    logic acc;
    assign acc = start && !busy;

    ccse_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign mem_wdata = {cmd.point_goal, cmd.point_seq, cmd.pos_y, cmd.pos_x};

    // fields of read data
    logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
    logic [SEQ_W-1:0] rd_seq;
    logic             rd_goal;
    assign rd_x    = mem_rdata[COORD_WIDTH-1:0];
    assign rd_y    = mem_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign rd_seq  = mem_rdata[ENT_W-2:2*COORD_WIDTH];
    assign rd_goal = mem_rdata[ENT_W-1];

    // magnitudes of differences, one bit wider
    logic signed [COORD_WIDTH:0] dx, dy;
    logic [COORD_WIDTH:0] adx, ady;
    assign dx  = (COORD_WIDTH+1)'(rd_x) - (COORD_WIDTH+1)'(qx_reg);
    assign dy  = (COORD_WIDTH+1)'(rd_y) - (COORD_WIDTH+1)'(qy_reg);
    assign adx = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dx) : dx;
    assign ady = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : dy;

    logic [DIST_W-1:0] dist_sum;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    logic seq_jump;
    assign seq_jump = (s1_i_reg != '0) &&
                      ({1'b0, rd_seq} > ({1'b0, prev_seq_reg} + (SEQ_W+1)'(1)));

    // scan datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= (state_reg == ST_SCAN);
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg <= rd_idx_reg[IDX_W-1:0];
        s2_i_reg <= s1_i_reg;
        if (acc)
        begin
            qx_reg   <= cmd.pos_x;
            qy_reg   <= cmd.pos_y;
            goal_reg <= 1'b0;
            fj_reg   <= count_reg;
            nj_reg   <= count_reg;
            c_reg    <= '0;
        end
        // stage 1: squares and jump detection
        if (s1_v_reg)
        begin
            sqx_reg      <= SQ_W'(adx * adx);
            sqy_reg      <= SQ_W'(ady * ady);
            prev_seq_reg <= rd_seq;
            lastseq_reg  <= rd_seq;
            jump2_reg    <= seq_jump;
            if (rd_goal)
            begin
                goal_reg <= 1'b1;
            end
        end
        // stage 2: compare and jump bookkeeping against the running best
        if (s2_v_reg)
        begin
            if (s2_i_reg == '0 || dist_sum < best_reg)
            begin
                best_reg <= dist_sum;
                c_reg    <= s2_i_reg;
                // a new best voids any jump seen before it
                nj_reg   <= count_reg;
            end
            else if (jump2_reg && nj_reg == count_reg)
            begin
                // first jump past the running best
                nj_reg <= CNT_W'(s2_i_reg);
            end
            if (jump2_reg && fj_reg == count_reg)
            begin
                fj_reg <= CNT_W'(s2_i_reg);
            end
        end
        end_reg  <= end_next;
        wrap_reg <= wrap_next;
        lead_reg <= lead_next;
        add_reg  <= add_next;
    end

    // control and emission pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            e_v_reg    <= 1'b0;
            e_last_reg <= 1'b0;
            e_wrap_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            e_v_reg    <= e_v_next;
            e_last_reg <= e_last_next;
            e_wrap_reg <= e_wrap_next;
        end
    end

    // start index of the segment
    logic [CNT_W-1:0] seg_start;
    assign seg_start = (CNT_W'(c_reg) >= CNT_W'(LOOKBACK)) ?
                       CNT_W'(c_reg) - CNT_W'(LOOKBACK) : '0;

    // control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        mem_we      = 1'b0;
        mem_raddr   = rd_idx_reg[IDX_W-1:0];
        end_next    = end_reg;
        wrap_next   = wrap_reg;
        lead_next   = lead_reg;
        add_next    = add_reg;
        e_v_next    = 1'b0;
        e_last_next = 1'b0;
        e_wrap_next = 1'b0;
        busy        = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (action_t'(cmd.action))
                        ACT_CLEAR:  count_next = '0;
                        ACT_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_POINTS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_idx_next = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (rd_idx_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                // wait until stage 2 has seen the last entry
                if (!s1_v_reg && !s2_v_reg)
                begin
                    end_next    = nj_reg;
                    wrap_next   = (nj_reg == count_reg) && !goal_reg;
                    lead_next   = (CNT_W'(c_reg) < fj_reg) ? CNT_W'(c_reg) : fj_reg;
                    add_next    = OSEQ_W'(lastseq_reg) + OSEQ_W'(1);
                    rd_idx_next = seg_start;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                mem_raddr   = rd_idx_reg[IDX_W-1:0];
                e_v_next    = 1'b1;
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (rd_idx_reg + CNT_W'(1) == end_reg)
                begin
                    if (wrap_reg && lead_reg != '0)
                    begin
                        rd_idx_next = '0;
                        state_next  = ST_WRAP;
                    end
                    else
                    begin
                        e_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_WRAP:
            begin
                mem_raddr   = rd_idx_reg[IDX_W-1:0];
                e_v_next    = 1'b1;
                e_wrap_next = 1'b1;
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (rd_idx_reg + CNT_W'(1) == lead_reg)
                begin
                    e_last_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // hold off new commands while a result other than the last is on the output
        if (e_v_reg && !e_last_reg)
        begin
            busy = 1'b1;
        end
    end

    // result transfer
    assign valid           = e_v_reg;
    assign result.out_seq  = OSEQ_W'(rd_seq) + (e_wrap_reg ? add_reg : '0);
    assign result.out_x    = rd_x;
    assign result.out_y    = rd_y;
    assign result.out_goal = rd_goal;
    assign result.last     = e_last_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.last |-> valid)
        else $error("last without valid");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> busy)
        else $error("not busy during query");
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("count changed during query");

endmodule

// ===== bench/tb_closest_continuous_segment_extract_unit.sv =====
module tb_closest_continuous_segment_extract_unit
    import ccse_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  cmd;
    logic      busy;
    logic      valid;
    out_item_t result;

    closest_continuous_segment_extract_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * MAX_POINTS + 20;

    // predictor's copy of the point store
    logic signed [COORD_WIDTH-1:0] px [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] py [MAX_POINTS];
    logic [SEQ_W-1:0]              pseq [MAX_POINTS];
    logic                          pgoal [MAX_POINTS];
    int                            npts;

    out_item_t segment_q[$];
    int        mismatches;
    int        cycles;
    bit        quiet_stretch;

    // directed stimulus; has_exp marks rows whose single result is typed in
    typedef struct {
        in_item_t  item;
        bit        has_exp;
        out_item_t exp;
    } row_t;
    row_t rows[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [2*COORD_WIDTH+2:0] sq_dist(int i, in_item_t c);
        logic signed [COORD_WIDTH:0] dx;
        logic signed [COORD_WIDTH:0] dy;
        logic [COORD_WIDTH:0]        ax;
        logic [COORD_WIDTH:0]        ay;
        dx = px[i] - c.pos_x;
        dy = py[i] - c.pos_y;
        ax = dx[COORD_WIDTH] ? -dx : dx;
        ay = dy[COORD_WIDTH] ? -dy : dy;
        return ({(2*COORD_WIDTH+3)'(0)} + ax * ax) + ({(2*COORD_WIDTH+3)'(0)} + ay * ay);
    endfunction

    function automatic out_item_t seg_point(int i, logic [OSEQ_W-1:0] add);
        out_item_t r;
        r.out_seq  = OSEQ_W'(pseq[i]) + add;
        r.out_x    = px[i];
        r.out_y    = py[i];
        r.out_goal = pgoal[i];
        r.last     = 1'b0;
        return r;
    endfunction

    // update the store copy and queue the segment a query produces
    task automatic predict_segment(in_item_t c);
        logic [2*COORD_WIDTH+2:0] best;
        logic [2*COORD_WIDTH+2:0] d;
        logic [OSEQ_W-1:0]        add;
        int  closest;
        int  first_jump;
        int  next_jump;
        int  first;
        int  lead;
        int  nres;
        bit  any_goal;
        out_item_t r;
        nres = 0;
        any_goal = 1'b0;
        case (action_t'(c.action))
            ACT_CLEAR: npts = 0;
            ACT_APPEND:
                if (npts < MAX_POINTS)
                begin
                    px[npts] = c.pos_x;
                    py[npts] = c.pos_y;
                    pseq[npts] = c.point_seq;
                    pgoal[npts] = c.point_goal;
                    npts++;
                end
            ACT_QUERY:
                if (npts > 0)
                begin
                    closest = 0;
                    best = '0;
                    for (int i = 0; i < npts; i++)
                    begin
                        d = sq_dist(i, c);
                        if (i == 0 || d < best)
                        begin
                            closest = i;
                            best = d;
                        end
                        if (pgoal[i])
                            any_goal = 1'b1;
                    end
                    first_jump = npts;
                    next_jump = npts;
                    for (int i = 1; i < npts; i++)
                        if (int'(pseq[i]) - int'(pseq[i-1]) > 1)
                        begin
                            if (first_jump == npts)
                                first_jump = i;
                            if (i > closest && next_jump == npts)
                                next_jump = i;
                        end
                    first = closest >= LOOKBACK ? closest - LOOKBACK : 0;
                    for (int i = first; i < next_jump; i++)
                    begin
                        segment_q = {segment_q, seg_point(i, '0)};
                        nres++;
                    end
                    // open path: wrap around to the leading points
                    if (next_jump == npts && !any_goal)
                    begin
                        add = OSEQ_W'(pseq[npts-1]) + 16'd1;
                        lead = closest < first_jump ? closest : first_jump;
                        for (int i = 0; i < lead; i++)
                        begin
                            segment_q = {segment_q, seg_point(i, add)};
                            nres++;
                        end
                    end
                    if (nres > 0)
                    begin
                        r = segment_q.pop_back();
                        r.last = 1'b1;
                        segment_q = {segment_q, r};
                    end
                end
            default: ;
        endcase
    endtask

    // compare each result transfer with the oldest expected point
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (segment_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                if (result !== segment_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", segment_q[0], result);
                end
                void'(segment_q.pop_front());
            end
        end
    end

    // overall time limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_item_t mk(action_t a, int s, logic [31:0] x, logic [31:0] y, bit g);
        in_item_t c;
        c.action = a;
        c.point_seq = SEQ_W'(s);
        c.pos_x = x;
        c.pos_y = y;
        c.point_goal = g;
        return c;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 14;
        endcase
    endfunction

    task automatic add_row(in_item_t c);
        row_t r;
        r.item = c;
        r.has_exp = 1'b0;
        r.exp = '0;
        rows = {rows, r};
    endtask

    task automatic add_row_exp(in_item_t c, out_item_t e);
        row_t r;
        r.item = c;
        r.has_exp = 1'b1;
        r.exp = e;
        rows = {rows, r};
    endtask

    // one command transfer, with random idle cycles before it unless quiet_stretch is set
    task automatic send(in_item_t c);
        if (!quiet_stretch)
            while ($urandom_range(0, 99) < 10)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        cmd   <= c;
        // the accepting edge: busy is still the value before the edge
        @(posedge clk iff !busy);
        predict_segment(c);
    endtask

    initial begin
        int   seq;
        int   len;
        out_item_t e;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        npts = 0;
        mismatches = 0;
        cycles = 0;
        quiet_stretch = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, unused code, single point at the extremes
        add_row(mk(ACT_QUERY, 0, 0, 0, 1'b0));
        add_row(mk(ACT_NONE, 5, 1, 1, 1'b1));
        add_row(mk(ACT_APPEND, 32767, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
        e = '{out_seq: 16'd32767, out_x: 32'h8000_0000, out_y: 32'h7fff_ffff,
              out_goal: 1'b0, last: 1'b1};
        add_row_exp(mk(ACT_QUERY, 0, 32'h7fff_ffff, 32'h8000_0000, 1'b0), e);
        add_row(mk(ACT_CLEAR, 0, 0, 0, 1'b0));
        add_row(mk(ACT_QUERY, 0, 0, 0, 1'b0));
        // path with a jump, a tie and wrap-around
        add_row(mk(ACT_APPEND, 10, 0, 0, 1'b0));
        add_row(mk(ACT_APPEND, 11, 32'h1_0000, 0, 1'b0));
        add_row(mk(ACT_APPEND, 12, 32'h2_0000, 0, 1'b0));
        add_row(mk(ACT_APPEND, 20, 32'h3_0000, 0, 1'b0));
        add_row(mk(ACT_APPEND, 21, 32'h4_0000, 0, 1'b0));
        add_row(mk(ACT_APPEND, 22, 32'h5_0000, 0, 1'b0));
        add_row(mk(ACT_QUERY, 0, 32'h1_8000, 0, 1'b0));
        add_row(mk(ACT_QUERY, 0, 32'h4_0000, 32'h1, 1'b0));
        add_row(mk(ACT_QUERY, 0, 32'hffff_0000, 0, 1'b0));
        add_row(mk(ACT_APPEND, 23, 32'h6_0000, 0, 1'b1));
        add_row(mk(ACT_QUERY, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        add_row(mk(ACT_QUERY, 0, 32'h8000_0000, 32'h8000_0000, 1'b0));
        add_row(mk(ACT_CLEAR, 0, 0, 0, 1'b0));

        foreach (rows[i])
        begin
            send(rows[i].item);
            if (rows[i].has_exp && (segment_q.size() != 1 || segment_q[0] !== rows[i].exp))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: typed expectation disagrees with prediction", i);
            end
        end

        // fill past capacity, then query the full store
        for (int i = 0; i < MAX_POINTS + 2; i++)
            send(mk(ACT_APPEND, i, rand_coord(), rand_coord(), 1'b0));
        repeat (3) send(mk(ACT_QUERY, 0, rand_coord(), rand_coord(), 1'b0));

        // random paths: mostly runs of consecutive sequence numbers
        for (int t = 0; t < 7; t++)
        begin
            quiet_stretch = (t == 3);
            send(mk(ACT_CLEAR, 0, 0, 0, 1'b0));
            seq = $urandom_range(0, 32767 - 200);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, MAX_POINTS + 1)
                                              : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                send(mk(ACT_APPEND, seq, rand_coord(), rand_coord(),
                        $urandom_range(0, 9) == 0));
                seq += ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 1;
                if (seq > 32767)
                    seq = 0;
                if ($urandom_range(0, 19) == 0)
                    send(mk(ACT_NONE, $urandom, $urandom, $urandom, 1'b1));
            end
            repeat ($urandom_range(1, 4))
                send(mk(ACT_QUERY, $urandom, rand_coord(), rand_coord(), 1'($urandom)));
        end
        quiet_stretch = 1'b0;
        start <= 1'b0;

        // let the last results arrive
        while (segment_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
